>>> hw/rtl/imufca_pkg.sv
`default_nettype none

package imufca_pkg;

  localparam int unsigned MAX_FRAME_DEF = 96;

  localparam logic [7:0] START_CODE = 8'h49;
  localparam logic [7:0] STOP_CODE = 8'h4D;
  localparam int unsigned MIN_FRAME_LEN = 4;

  localparam logic [6:0] MIN_REPORT_LEN_RST = 7'd78;
  localparam logic [6:0] ANGLE_OFFSET_RST = 7'd50;
  localparam logic [6:0] SAMPLE_OFFSET_RST = 7'd10;
  localparam logic [15:0] ANGLE_GAIN_RST = 16'd54931;

  // divide by 100000 as (n >> 5) / 3125, the latter by reciprocal multiply
  localparam logic [31:0] ROUND_HALF = 32'd50000;
  localparam int unsigned DIV_PRE_SHIFT = 5;
  localparam int unsigned DIV_IN_W = 32 - DIV_PRE_SHIFT;
  localparam logic [27:0] DIV_RECIP = 28'd175921861;
  localparam int unsigned DIV_RECIP_SHIFT = 39;
  localparam int unsigned DIV_PROD_W = DIV_IN_W + 28;

  localparam logic [15:0] SAT_POS = 16'd32767;
  localparam logic [15:0] SAT_NEG_MAG = 16'd32768;

  typedef enum logic [1:0] {
    REG_MIN_REPORT_LEN = 2'd0,
    REG_ANGLE_OFFSET   = 2'd1,
    REG_SAMPLE_OFFSET  = 2'd2,
    REG_ANGLE_GAIN     = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [6:0] min_report_len;
    logic [6:0] angle_offset;
    logic [6:0] sample_offset;
  } frame_cfg_t;

  typedef struct packed {
    logic             ok;
    logic [6:0]       len;
    logic             rep;
    logic [2:0][15:0] angle;
    logic [15:0]      sample;
  } frame_sum_t;

  typedef struct packed {
    logic        ok;
    logic [6:0]  len;
    logic        rep;
    logic [15:0] sample;
  } frame_meta_t;

  function automatic logic [15:0] put_byte(input logic [15:0] word, input logic [8:0] idx,
                                           input logic [8:0] base, input logic [7:0] b);
    logic [15:0] r;
    r = word;
    if (idx == base) begin
      r[7:0] = b;
    end else if (idx == base + 9'd1) begin
      r[15:8] = b;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/imufca_frame.sv
`default_nettype none

module imufca_frame #(
  parameter int unsigned MAX_FRAME = imufca_pkg::MAX_FRAME_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          accept_i,
  input  wire  [7:0]                   rx_byte_i,
  input  wire                          burst_end_i,
  input  wire  imufca_pkg::frame_cfg_t cfg_i,
  output imufca_pkg::frame_sum_t       sum_o
);

  localparam int unsigned CntW = $clog2(MAX_FRAME + 1);

  logic [CntW-1:0]  count_q, count_d, len_eff;
  logic [7:0]       first_q, first_d;
  logic [7:0]       lag0_q, lag0_d, lag1_q, lag1_d;
  logic [7:0]       csum_q, csum_d;
  logic [2:0][15:0] raw_q, raw_d;
  logic [15:0]      smp_q, smp_d;
  logic             room, opening, ok;
  logic [8:0]       idx;
  logic [7:0]       chk;

  assign room    = count_q < CntW'(MAX_FRAME);
  assign opening = count_q == '0;
  assign idx     = 9'(count_q);

  always_comb begin
    count_d = count_q;
    first_d = first_q;
    lag0_d  = lag0_q;
    lag1_d  = lag1_q;
    csum_d  = csum_q;
    raw_d   = raw_q;
    smp_d   = smp_q;
    if (room) begin
      count_d = count_q + CntW'(1);
      first_d = opening ? rx_byte_i : first_q;
      csum_d  = opening ? 8'd0 : csum_q + rx_byte_i;
      lag0_d  = opening ? 8'd0 : lag1_q;
      lag1_d  = rx_byte_i;
      for (int k = 0; k < 3; k++) begin
        raw_d[k] = imufca_pkg::put_byte(opening ? 16'd0 : raw_q[k], idx,
                                        9'(cfg_i.angle_offset) + 9'(2 * k), rx_byte_i);
      end
      smp_d = imufca_pkg::put_byte(opening ? 16'd0 : smp_q, idx,
                                   9'(cfg_i.sample_offset), rx_byte_i);
    end
  end

  assign len_eff = count_d;
  assign chk     = csum_d - lag0_d - lag1_d;
  assign ok      = (len_eff >= CntW'(imufca_pkg::MIN_FRAME_LEN)) &&
                   (first_d == imufca_pkg::START_CODE) &&
                   (lag1_d == imufca_pkg::STOP_CODE) && (chk == lag0_d);

  always_comb begin
    sum_o.ok     = ok;
    sum_o.len    = 7'(len_eff);
    sum_o.rep    = ok && (8'(len_eff) >= 8'(cfg_i.min_report_len));
    sum_o.angle  = sum_o.rep ? raw_d : '0;
    sum_o.sample = sum_o.rep ? smp_d : 16'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      first_q <= '0;
      lag0_q  <= '0;
      lag1_q  <= '0;
      csum_q  <= '0;
      raw_q   <= '0;
      smp_q   <= '0;
    end else if (accept_i) begin
      count_q <= burst_end_i ? '0 : count_d;
      first_q <= first_d;
      lag0_q  <= lag0_d;
      lag1_q  <= lag1_d;
      csum_q  <= csum_d;
      raw_q   <= raw_d;
      smp_q   <= smp_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/imu_frame_check_angle_extract.sv
// Response frame checker with angle extraction.
// Slave stream: one received byte per word in s_axis_tdata[7:0]; s_axis_tlast
// marks the final byte of a burst and closes the frame. Each burst yields one
// result word on the master stream; bytes without tlast yield none.
// Result: tdata holds frame_len, angle_x, angle_y, angle_z and sample_word;
// tuser bit 0 is frame_ok, bit 1 is is_report. Angles and sample are zero
// unless the frame is a report.
// Throughput: one byte per cycle while the pipeline can take it; the frame state
// updates on each accepted byte. A tlast byte's result passes through the snapshot,
// gain multiply, round, reciprocal multiply and output registers in that order.
// Stall: a full pipeline stage holds while the next one cannot load; the block
// keeps taking bytes while a result waits until the pipeline fills.
// Reset: frame state clears, the pipeline empties and the registers return
// to min_report_len 78, angle_offset 50, sample_offset 10, angle_gain 54931.
// The user writes the APB port only while no burst is in flight; not enforced by the block.
`default_nettype none

module imu_frame_check_angle_extract #(
  parameter int unsigned MAX_FRAME = imufca_pkg::MAX_FRAME_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,  // [7:0] rx_byte
  input  wire         s_axis_tlast,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [71:0] m_axis_tdata,  // frame_len, angle_x, angle_y, angle_z, sample_word, pad
  output logic [1:0]  m_axis_tuser,  // frame_ok, is_report
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [3:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  imufca_pkg::frame_cfg_t cfg_q;
  logic [15:0]            gain_q;
  imufca_pkg::reg_idx_e   reg_idx;
  imufca_pkg::frame_sum_t fsum;
  logic                   in_acc;

  assign pready  = 1'b1;
  assign reg_idx = imufca_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_report_len <= imufca_pkg::MIN_REPORT_LEN_RST;
      cfg_q.angle_offset   <= imufca_pkg::ANGLE_OFFSET_RST;
      cfg_q.sample_offset  <= imufca_pkg::SAMPLE_OFFSET_RST;
      gain_q               <= imufca_pkg::ANGLE_GAIN_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        imufca_pkg::REG_MIN_REPORT_LEN: cfg_q.min_report_len <= pwdata[6:0];
        imufca_pkg::REG_ANGLE_OFFSET:   cfg_q.angle_offset   <= pwdata[6:0];
        imufca_pkg::REG_SAMPLE_OFFSET:  cfg_q.sample_offset  <= pwdata[6:0];
        imufca_pkg::REG_ANGLE_GAIN:     gain_q               <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      imufca_pkg::REG_MIN_REPORT_LEN: prdata = 32'(cfg_q.min_report_len);
      imufca_pkg::REG_ANGLE_OFFSET:   prdata = 32'(cfg_q.angle_offset);
      imufca_pkg::REG_SAMPLE_OFFSET:  prdata = 32'(cfg_q.sample_offset);
      imufca_pkg::REG_ANGLE_GAIN:     prdata = 32'(gain_q);
      default:                        prdata = 32'd0;
    endcase
  end

  // pipeline control
  logic v1_q, v2_q, v3_q, v4_q, vo_q;
  logic ld1, ld2, ld3, ld4, ldo;

  assign ldo = !vo_q || m_axis_tready;
  assign ld4 = !v4_q || ldo;
  assign ld3 = !v3_q || ld4;
  assign ld2 = !v2_q || ld3;
  assign ld1 = !v1_q || ld2;

  assign s_axis_tready = ld1;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  imufca_frame #(
    .MAX_FRAME(MAX_FRAME)
  ) u_frame (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (in_acc),
    .rx_byte_i  (s_axis_tdata),
    .burst_end_i(s_axis_tlast),
    .cfg_i      (cfg_q),
    .sum_o      (fsum)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (ld1) v1_q <= in_acc && s_axis_tlast;
      if (ld2) v2_q <= v1_q;
      if (ld3) v3_q <= v2_q;
      if (ld4) v4_q <= v3_q;
      if (ldo) vo_q <= v4_q;
    end
  end

  imufca_pkg::frame_meta_t m1_q, m2_q, m3_q, m4_q, mo_q;
  logic [2:0][15:0]                      raw1_q;
  logic signed [32:0]                    prod2_q [3];
  logic [2:0]                            neg3_q, neg4_q;
  logic [imufca_pkg::DIV_IN_W-1:0]       num3_q [3];
  logic [15:0]                           quo4_q [3];
  logic [2:0][15:0]                      ang_q;

  always_ff @(posedge clk_i) begin
    if (ld1) begin
      m1_q.ok     <= fsum.ok;
      m1_q.len    <= fsum.len;
      m1_q.rep    <= fsum.rep;
      m1_q.sample <= fsum.sample;
      raw1_q      <= fsum.angle;
    end
    if (ld2) m2_q <= m1_q;
    if (ld3) m3_q <= m2_q;
    if (ld4) m4_q <= m3_q;
    if (ldo) mo_q <= m4_q;
  end

  for (genvar k = 0; k < 3; k++) begin : g_lane
    logic [31:0]                        mag;
    logic [31:0]                        rnd;
    logic [imufca_pkg::DIV_PROD_W-1:0]  qprod;
    logic [15:0]                        sat;

    assign mag   = prod2_q[k][32] ? 32'(-prod2_q[k]) : 32'(prod2_q[k]);
    assign rnd   = mag + imufca_pkg::ROUND_HALF;
    assign qprod = imufca_pkg::DIV_PROD_W'(num3_q[k]) *
                   imufca_pkg::DIV_PROD_W'(imufca_pkg::DIV_RECIP);

    always_comb begin
      if (neg4_q[k]) begin
        sat = (quo4_q[k] > imufca_pkg::SAT_NEG_MAG) ? imufca_pkg::SAT_NEG_MAG : -quo4_q[k];
      end else begin
        sat = (quo4_q[k] > imufca_pkg::SAT_POS) ? imufca_pkg::SAT_POS : quo4_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ld2) prod2_q[k] <= $signed(raw1_q[k]) * $signed({1'b0, gain_q});
      if (ld3) begin
        neg3_q[k] <= prod2_q[k][32];
        num3_q[k] <= rnd[31:imufca_pkg::DIV_PRE_SHIFT];
      end
      if (ld4) begin
        neg4_q[k] <= neg3_q[k];
        quo4_q[k] <= qprod[imufca_pkg::DIV_RECIP_SHIFT +: 16];
      end
      if (ldo) ang_q[k] <= sat;
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = {1'b0, mo_q.sample, ang_q[2], ang_q[1], ang_q[0], mo_q.len};
  assign m_axis_tuser  = {mo_q.rep, mo_q.ok};

endmodule

`default_nettype wire

>>> tb/imu_frame_check_angle_extract_tb.sv
`timescale 1ns / 1ps

module imu_frame_check_angle_extract_tb;

  localparam int unsigned FRAME_CAP = imufca_pkg::MAX_FRAME_DEF;
  localparam int unsigned ITEMS = 1200;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef enum int {
    FLAW_NONE,
    FLAW_START,
    FLAW_STOP,
    FLAW_SUM,
    FLAW_NOISE
  } frame_flaw_e;

  typedef struct packed {
    logic        ok;
    logic [6:0]  len;
    logic        rep;
    logic [15:0] ax;
    logic [15:0] ay;
    logic [15:0] az;
    logic [15:0] smp;
  } frame_result_t;

  class frame_scoreboard;
    logic [6:0]  min_len;
    logic [6:0]  ang_off;
    logic [6:0]  smp_off;
    logic [15:0] gain;

    int unsigned count;
    logic [7:0]  first;
    logic [7:0]  lag0;
    logic [7:0]  lag1;
    logic [7:0]  sum;
    logic [15:0] raw [3];
    logic [15:0] smp;

    frame_result_t expected_q[$];
    int unsigned   checked;
    int unsigned   errors;

    function new();
      min_len = imufca_pkg::MIN_REPORT_LEN_RST;
      ang_off = imufca_pkg::ANGLE_OFFSET_RST;
      smp_off = imufca_pkg::SAMPLE_OFFSET_RST;
      gain    = imufca_pkg::ANGLE_GAIN_RST;
      checked = 0;
      errors  = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      count = 0;
      first = 8'd0;
      lag0  = 8'd0;
      lag1  = 8'd0;
      sum   = 8'd0;
      for (int k = 0; k < 3; k++) raw[k] = 16'd0;
      smp = 16'd0;
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    function void write_reg(imufca_pkg::reg_idx_e idx, logic [31:0] v);
      case (idx)
        imufca_pkg::REG_MIN_REPORT_LEN: min_len = v[6:0];
        imufca_pkg::REG_ANGLE_OFFSET:   ang_off = v[6:0];
        imufca_pkg::REG_SAMPLE_OFFSET:  smp_off = v[6:0];
        imufca_pkg::REG_ANGLE_GAIN:     gain    = v[15:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] reg_value(imufca_pkg::reg_idx_e idx);
      case (idx)
        imufca_pkg::REG_MIN_REPORT_LEN: return {25'd0, min_len};
        imufca_pkg::REG_ANGLE_OFFSET:   return {25'd0, ang_off};
        imufca_pkg::REG_SAMPLE_OFFSET:  return {25'd0, smp_off};
        default:                        return {16'd0, gain};
      endcase
    endfunction

    function logic [15:0] merge_byte(logic [15:0] w, int unsigned idx, int unsigned base,
                                     logic [7:0] b);
      if (idx == base) return {w[15:8], b};
      if (idx == base + 1) return {b, w[7:0]};
      return w;
    endfunction

    function logic [15:0] scale_angle(logic [15:0] r);
      longint v;
      longint g;
      longint d;
      v = $signed(r);
      g = gain;
      d = v * g;
      if (d >= 0) d = (d + 50000) / 100000;
      else d = -((-d + 50000) / 100000);
      if (d > 32767) d = 32767;
      if (d < -32768) d = -32768;
      return d[15:0];
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      frame_result_t e;
      logic [7:0] chk;
      if (count < FRAME_CAP) begin
        if (count == 0) begin
          clear_frame();
          first = b;
        end else begin
          sum = sum + b;
        end
        lag0 = lag1;
        lag1 = b;
        for (int k = 0; k < 3; k++) raw[k] = merge_byte(raw[k], count, ang_off + 2 * k, b);
        smp = merge_byte(smp, count, smp_off, b);
        count++;
      end
      if (last) begin
        chk = sum - lag0 - lag1;
        e.ok = (count >= imufca_pkg::MIN_FRAME_LEN) && (first == imufca_pkg::START_CODE) &&
               (lag1 == imufca_pkg::STOP_CODE) && (chk == lag0);
        e.len = count[6:0];
        e.rep = e.ok && (count >= min_len);
        e.ax  = e.rep ? scale_angle(raw[0]) : 16'd0;
        e.ay  = e.rep ? scale_angle(raw[1]) : 16'd0;
        e.az  = e.rep ? scale_angle(raw[2]) : 16'd0;
        e.smp = e.rep ? smp : 16'd0;
        expected_q.push_back(e);
        clear_frame();
      end
    endfunction

    task compare(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
        report($sformatf("result %0d %s: got %0h, want %0h", checked, name, got, want));
    endtask

    task check(logic [71:0] d, logic [1:0] u);
      frame_result_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("result %0d arrived with no frame closed", checked));
        checked++;
        return;
      end
      e = expected_q.pop_front();
      compare("frame_ok", {15'd0, u[0]}, {15'd0, e.ok});
      compare("is_report", {15'd0, u[1]}, {15'd0, e.rep});
      compare("frame_len", {9'd0, d[6:0]}, {9'd0, e.len});
      compare("angle_x", d[22:7], e.ax);
      compare("angle_y", d[38:23], e.ay);
      compare("angle_z", d[54:39], e.az);
      compare("sample_word", d[70:55], e.smp);
      checked++;
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;  // [7:0] rx_byte
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;  // frame_len, angle_x, angle_y, angle_z, sample_word, pad
  logic [1:0]  m_axis_tuser;  // frame_ok, is_report
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = 4'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  frame_scoreboard sb = new();

  int unsigned cycles = 0;
  int unsigned bytes_sent = 0;
  int unsigned burst_left = 0;
  int unsigned cfg_mrl = imufca_pkg::MIN_REPORT_LEN_RST;
  int unsigned cfg_ang = imufca_pkg::ANGLE_OFFSET_RST;
  int unsigned cfg_smp = imufca_pkg::SAMPLE_OFFSET_RST;
  bit          hold_req = 1'b0;

  imu_frame_check_angle_extract dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("imu_frame_check_angle_extract verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check(m_axis_tdata, m_axis_tuser);
  end

  initial begin
    int unsigned mode;
    int unsigned stretch;
    mode = 0;
    stretch = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      if (stretch == 0) begin
        mode = $urandom_range(0, 3);
        stretch = $urandom_range(5, 60);
      end
      stretch--;
      case (mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        2: m_axis_tready <= ($urandom_range(0, 4) == 0);
        default: m_axis_tready <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  task automatic apb_access(input logic wr, input imufca_pkg::reg_idx_e idx,
                            input logic [31:0] data, output logic [31:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    if (wr) sb.write_reg(idx, data);
  endtask

  task automatic set_config(input int unsigned mrl, input int unsigned ang,
                            input int unsigned smp, input int unsigned gain);
    logic [31:0]          vals [4];
    logic [31:0]          rd;
    imufca_pkg::reg_idx_e idx;
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    vals[0] = mrl;
    vals[1] = ang;
    vals[2] = smp;
    vals[3] = gain;
    for (int i = 0; i < 4; i++) begin
      idx = imufca_pkg::reg_idx_e'(i);
      apb_access(1'b1, idx, vals[i], rd);
      apb_access(1'b0, idx, 32'd0, rd);
      if (rd !== sb.reg_value(idx))
        sb.report($sformatf("register %0d read %0h, want %0h", i, rd, sb.reg_value(idx)));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_mrl = mrl;
    cfg_ang = ang;
    cfg_smp = smp;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_byte(b, last);
    burst_left--;
    bytes_sent++;
  endtask

  // words: angle x, angle y, angle z, sample; placed at the current offsets
  task automatic send_frame(input int unsigned len, input frame_flaw_e flaw,
                            input int unsigned extra, input logic [3:0][15:0] words);
    logic [7:0]  fb[$];
    logic [7:0]  s;
    int unsigned pos;
    fb = {};
    for (int i = 0; i < len; i++) fb.push_back(8'($urandom_range(0, 255)));
    for (int k = 0; k < 4; k++) begin
      pos = (k < 3) ? cfg_ang + 2 * k : cfg_smp;
      if (pos < len) fb[pos] = words[k][7:0];
      if (pos + 1 < len) fb[pos + 1] = words[k][15:8];
    end
    fb[0] = imufca_pkg::START_CODE;
    s = 8'd0;
    for (int i = 1; i + 3 <= len; i++) s = s + fb[i];
    if (len >= 2) fb[len - 2] = s;
    fb[len - 1] = imufca_pkg::STOP_CODE;
    case (flaw)
      FLAW_START: fb[0] = fb[0] ^ (8'd1 << $urandom_range(0, 7));
      FLAW_STOP:  fb[len - 1] = fb[len - 1] ^ (8'd1 << $urandom_range(0, 7));
      FLAW_SUM:   if (len >= 2) fb[len - 2] = fb[len - 2] ^ (8'd1 << $urandom_range(0, 7));
      FLAW_NOISE: for (int i = 0; i < len; i++) fb[i] = 8'($urandom_range(0, 255));
      default: ;
    endcase
    repeat (extra) fb.push_back(8'($urandom_range(0, 255)));
    for (int i = 0; i < fb.size(); i++) send_byte(fb[i], i == fb.size() - 1);
  endtask

  function automatic logic [3:0][15:0] random_words();
    logic [3:0][15:0] w;
    for (int k = 0; k < 4; k++) begin
      case ($urandom_range(0, 7))
        0: w[k] = 16'h8000;
        1: w[k] = 16'h7fff;
        2: w[k] = 16'hffff;
        default: w[k] = 16'($urandom_range(0, 65535));
      endcase
    end
    return w;
  endfunction

  initial begin
    int unsigned phase;
    int unsigned len;
    int unsigned lo;
    int unsigned hi;
    int unsigned extra;
    int unsigned sel;
    frame_flaw_e flaw;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings first
    send_frame(78, FLAW_NONE, 0, {16'ha55a, 16'hffff, 16'h8000, 16'h7fff});
    send_frame(77, FLAW_NONE, 0, {16'h1234, 16'h0001, 16'h0000, 16'h8000});
    send_frame(96, FLAW_NONE, 0, {16'h0000, 16'h7fff, 16'h8001, 16'h0100});
    send_frame(96, FLAW_NONE, 5, {16'hbeef, 16'h4000, 16'hc000, 16'h00ff});
    send_frame(80, FLAW_START, 0, random_words());
    send_frame(80, FLAW_STOP, 0, random_words());
    send_frame(80, FLAW_SUM, 0, random_words());
    send_frame(1, FLAW_NONE, 0, random_words());
    send_frame(2, FLAW_NONE, 0, random_words());
    send_frame(3, FLAW_NONE, 0, random_words());

    // words partly past the end of the frame
    set_config(4, 0, 94, 0);
    send_frame(4, FLAW_NONE, 0, {16'hffff, 16'h7fff, 16'h8000, 16'h1234});
    send_frame(20, FLAW_NONE, 0, random_words());

    set_config(96, 90, 0, 65535);
    send_frame(96, FLAW_NONE, 0, {16'h4321, 16'h0001, 16'h7fff, 16'h8000});
    send_frame(95, FLAW_NONE, 0, random_words());

    // half-way products round away from zero
    set_config(8, 1, 7, 50000);
    send_frame(12, FLAW_NONE, 0, {16'hbeef, 16'h0002, 16'hffff, 16'h0001});
    send_frame(12, FLAW_NONE, 0, {16'h0000, 16'hfffd, 16'h0003, 16'hfffe});

    phase = 0;
    while (bytes_sent < ITEMS) begin
      phase++;
      sel = $urandom_range(0, 7);
      if (phase == 1 || sel > 1) begin
        lo = $urandom_range(4, 20);
        set_config(lo, $urandom_range(0, lo), $urandom_range(0, lo + 2),
                   $urandom_range(0, 65535));
      end else if (sel == 0) begin
        set_config(4, 0, 0, 0);
      end else begin
        set_config(96, 90, 94, 65535);
      end
      if (phase == 1) hold_req = 1'b1;
      repeat (10) begin
        extra = 0;
        case ($urandom_range(0, 9))
          0: len = $urandom_range(1, 3);
          1: begin
            len = $urandom_range(60, FRAME_CAP);
            if ($urandom_range(0, 1) == 1) begin
              len = FRAME_CAP;
              extra = $urandom_range(1, 6);
            end
          end
          default: begin
            lo = (cfg_mrl > 6) ? cfg_mrl - 2 : 4;
            hi = (cfg_mrl + 6 < FRAME_CAP) ? cfg_mrl + 6 : FRAME_CAP;
            len = $urandom_range(lo, hi);
          end
        endcase
        sel = $urandom_range(0, 9);
        if (sel < 6) flaw = FLAW_NONE;
        else if (sel == 6) flaw = FLAW_START;
        else if (sel == 7) flaw = FLAW_STOP;
        else if (sel == 8) flaw = FLAW_SUM;
        else flaw = FLAW_NOISE;
        send_frame(len, flaw, extra, random_words());
      end
    end

    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("imu_frame_check_angle_extract verification clean");
    end else begin
      $display("imu_frame_check_angle_extract verification failed");
    end
    $finish;
  end

endmodule
